@@ rtl/sbfr_pkg.sv @@
// Shared types and constants of the SBUS frame receiver.
package sbfr_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int FRAME_LENGTH  = 25;
  localparam int TIME_WIDTH    = 32;
  localparam int STORED_BYTES  = FRAME_LENGTH - 1;
  localparam int CH_WIDTH      = 11;
  localparam int COUNT_WIDTH   = $clog2(FRAME_LENGTH);
  localparam int CH_IDX_WIDTH  = $clog2(CHANNEL_COUNT);
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_ADDR_WIDTH = 3;

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam int LOST_BIT_POS = 2;
  localparam int FS_BIT_POS   = 3;

  // opcodes
  localparam logic [2:0] OP_RX_BYTE = 3'd0;
  localparam logic [2:0] OP_IDLE    = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_ERROR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_TAKE    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ONLINE_TIMEOUT = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MIDDLE_LOW     = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MIDDLE_HIGH    = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_EVENT_COOLDOWN = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SWITCH_CHANNEL = 3'd4;

  // switch classes
  localparam logic [1:0] POS_LOW    = 2'd0;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam logic [1:0] POS_HIGH   = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] rx_byte;
    logic [4:0] channel_index;
  } in_item_t;

  typedef struct packed {
    logic [CH_WIDTH-1:0] channel_value;
    logic                online;
    logic                failsafe;
    logic                lost_frame;
    logic [1:0]          switch_position;
    logic                middle_event;
    logic                frame_accepted;
  } out_item_t;

endpackage

@@ rtl/sbfr_ifs.sv @@
// Valid/ready word channels for input items and result items.
interface sbfr_in_if;
  logic               valid;
  logic               ready;
  sbfr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbfr_out_if;
  logic                valid;
  logic                ready;
  sbfr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sbus_frame_receiver_unit.sv @@
// SBUS frame receiver: byte collection, frame unpack, link and switch status.
// A word passes through the input register and then the result register before its result is offered.
// Throughput: one word per cycle; both stages advance together whenever the
// result register is empty or being taken, so stalls only come from the sink.
// Reset: synchronous, active low; clears control, status, times and config to
// defaults. The 24-byte frame store is not reset (every byte is written before use).
module sbus_frame_receiver_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sbfr_in_if.sink                               in_if,
  sbfr_out_if.source                            out_if,
  input  logic                                  cfg_we,
  input  logic [sbfr_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
  input  logic [sbfr_pkg::CFG_WIDTH-1:0]        cfg_wdata
);

  localparam int TW  = sbfr_pkg::TIME_WIDTH;
  localparam int CW  = sbfr_pkg::CH_WIDTH;
  localparam int NCH = sbfr_pkg::CHANNEL_COUNT;
  localparam int NB  = sbfr_pkg::STORED_BYTES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0]                         timeout_r;
  logic [CW-1:0]                       mid_lo_r;
  logic [CW-1:0]                       mid_hi_r;
  logic [15:0]                         cooldown_r;
  logic [sbfr_pkg::CH_IDX_WIDTH-1:0]   sw_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= 16'd300;
      mid_lo_r   <= CW'(700);
      mid_hi_r   <= CW'(1300);
      cooldown_r <= 16'd500;
      sw_ch_r    <= sbfr_pkg::CH_IDX_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbfr_pkg::CFG_ONLINE_TIMEOUT: timeout_r  <= cfg_wdata;
        sbfr_pkg::CFG_MIDDLE_LOW:     mid_lo_r   <= cfg_wdata[CW-1:0];
        sbfr_pkg::CFG_MIDDLE_HIGH:    mid_hi_r   <= cfg_wdata[CW-1:0];
        sbfr_pkg::CFG_EVENT_COOLDOWN: cooldown_r <= cfg_wdata;
        sbfr_pkg::CFG_SWITCH_CHANNEL: sw_ch_r    <= cfg_wdata[sbfr_pkg::CH_IDX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register and result register advance together
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  sbfr_pkg::in_item_t s1_r;
  logic               out_valid_r;
  sbfr_pkg::out_item_t out_r;
  sbfr_pkg::out_item_t out_nxt;
  logic               advance;
  logic               fire;

  assign advance      = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || advance;
  assign fire         = s1_valid_r && advance;   // word in s1 executes now
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (advance)     out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) s1_r <= in_if.data;
    if (fire) out_r <= out_nxt;
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [7:0]                         fb_r [NB];     // frame store, bytes 0..23
  logic [sbfr_pkg::COUNT_WIDTH-1:0]   count_r, count_nxt;
  logic [CW-1:0]                      chan_r [NCH];
  logic [CW-1:0]                      chan_nxt [NCH];
  logic                               online_r, online_nxt;
  logic                               fs_r, fs_nxt;
  logic                               lost_r, lost_nxt;
  logic                               was_mid_r, was_mid_nxt;
  logic                               latch_r, latch_nxt;
  logic [TW-1:0]                      time_r, time_nxt;
  logic [TW-1:0]                      last_frame_r, last_frame_nxt;
  logic [TW-1:0]                      last_event_r, last_event_nxt;
  logic                               byte_we;

  // Frame store flattened; channel ch sits at bit 8 + 11*ch, LSB first.
  logic [NB*8-1:0]                    flat;
  logic [CW-1:0]                      unpacked [NCH];

  always_comb begin
    for (int i = 0; i < NB; i++) flat[i*8 +: 8] = fb_r[i];
    for (int c = 0; c < NCH; c++) unpacked[c] = flat[8 + CW*c +: CW];
  end

  function automatic logic [1:0] classify(input logic [CW-1:0] v,
                                          input logic [CW-1:0] lo,
                                          input logic [CW-1:0] hi);
    logic [1:0] cls;
    if (v < lo)       cls = sbfr_pkg::POS_LOW;
    else if (v <= hi) cls = sbfr_pkg::POS_MIDDLE;
    else              cls = sbfr_pkg::POS_HIGH;
    return cls;
  endfunction

  logic          hdr_ok;
  logic          mid_new;
  logic          cool_ok;
  logic          accepted;
  logic [CW-1:0] chval;
  logic          ev_out;
  logic [1:0]    sw_pos;

  assign hdr_ok  = (fb_r[0] == sbfr_pkg::HDR_BYTE);
  assign mid_new = (classify(unpacked[sw_ch_r], mid_lo_r, mid_hi_r) == sbfr_pkg::POS_MIDDLE);
  assign cool_ok = ((time_r - last_event_r) >= TW'(cooldown_r));

  always_comb begin
    count_nxt      = count_r;
    chan_nxt       = chan_r;
    online_nxt     = online_r;
    fs_nxt         = fs_r;
    lost_nxt       = lost_r;
    was_mid_nxt    = was_mid_r;
    latch_nxt      = latch_r;
    time_nxt       = time_r;
    last_frame_nxt = last_frame_r;
    last_event_nxt = last_event_r;
    byte_we        = 1'b0;
    accepted       = 1'b0;
    chval          = '0;

    if (fire) begin
      unique case (s1_r.opcode)
        sbfr_pkg::OP_RX_BYTE: begin
          if (count_r < sbfr_pkg::COUNT_WIDTH'(NB)) begin
            byte_we   = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            // footer: parse what was collected, never stored
            count_nxt = '0;
            if (hdr_ok) begin
              accepted       = 1'b1;
              chan_nxt       = unpacked;
              lost_nxt       = fb_r[NB-1][sbfr_pkg::LOST_BIT_POS];
              fs_nxt         = fb_r[NB-1][sbfr_pkg::FS_BIT_POS];
              online_nxt     = !fb_r[NB-1][sbfr_pkg::FS_BIT_POS];
              last_frame_nxt = time_r;
              if (mid_new && !was_mid_r && cool_ok) begin
                latch_nxt      = 1'b1;
                last_event_nxt = time_r;
              end
              was_mid_nxt = mid_new;
            end
          end
        end
        sbfr_pkg::OP_IDLE: count_nxt = '0;
        sbfr_pkg::OP_TICK: begin
          time_nxt = time_r + 1'b1;
          if (online_r && ((time_nxt - last_frame_r) > TW'(timeout_r))) begin
            online_nxt  = 1'b0;
            was_mid_nxt = 1'b0;
          end
        end
        sbfr_pkg::OP_ERROR: begin
          count_nxt   = '0;
          online_nxt  = 1'b0;
          was_mid_nxt = 1'b0;
        end
        sbfr_pkg::OP_READ: begin
          if (!s1_r.channel_index[4]) chval = chan_r[s1_r.channel_index[3:0]];
        end
        default: ;   // take-event handled below; unused codes report status
      endcase
    end

    // take-event reports the latch as it was, then clears it
    ev_out = latch_nxt;
    if (fire && (s1_r.opcode == sbfr_pkg::OP_TAKE)) latch_nxt = 1'b0;
  end

  assign sw_pos = classify(chan_nxt[sw_ch_r], mid_lo_r, mid_hi_r);

  always_comb begin
    out_nxt.channel_value   = chval;
    out_nxt.online          = online_nxt;
    out_nxt.failsafe        = fs_nxt;
    out_nxt.lost_frame      = lost_nxt;
    out_nxt.switch_position = sw_pos;
    out_nxt.middle_event    = ev_out;
    out_nxt.frame_accepted  = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      online_r     <= 1'b0;
      fs_r         <= 1'b0;
      lost_r       <= 1'b0;
      was_mid_r    <= 1'b0;
      latch_r      <= 1'b0;
      time_r       <= '0;
      last_frame_r <= '0;
      last_event_r <= '0;
      for (int c = 0; c < NCH; c++) chan_r[c] <= '0;
    end else begin
      count_r      <= count_nxt;
      online_r     <= online_nxt;
      fs_r         <= fs_nxt;
      lost_r       <= lost_nxt;
      was_mid_r    <= was_mid_nxt;
      latch_r      <= latch_nxt;
      time_r       <= time_nxt;
      last_frame_r <= last_frame_nxt;
      last_event_r <= last_event_nxt;
      chan_r       <= chan_nxt;
    end
  end

  // frame store: written at the byte count, no reset
  always_ff @(posedge clk) begin
    if (byte_we) fb_r[count_r] <= s1_r.rx_byte;
  end

`ifndef SYNTHESIS
  a_accept_online: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_accepted |-> (out_r.online == !out_r.failsafe))
    else $error("accepted frame with online not the inverse of failsafe");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sbfr_pkg::COUNT_WIDTH'(NB))
    else $error("byte count beyond stored bytes");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input stalled with result register empty");

  a_pos_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.switch_position != 2'd3))
    else $error("switch position out of range");
`endif

endmodule
